@@ hdl/hbs_pkg.sv @@
// Shared constants and types for the hash bucket scatter block.
`timescale 1ns / 1ps
`default_nettype none
package hbs_pkg;

   // Table geometry and field widths
   localparam int HASH_ENTRIES = 1024;
   localparam int HASH_W       = $clog2(HASH_ENTRIES);
   localparam int LOAD_IDX_W   = HASH_W + 1;
   localparam int MAX_CHUNKS   = 65536;
   localparam int COUNT_W      = 17;
   localparam int SUM_W        = COUNT_W + 1;
   localparam int POS_W        = 32;
   localparam int SLOT_W       = 16;
   localparam int NAME_W       = 16;
   localparam int OP_W         = 2;

   // Table entry: used flag above the bucket end
   localparam int ENTRY_W      = COUNT_W + 1;

   // Stream word widths
   localparam int REQ_DATA_W   = 64;
   localparam int RSP_DATA_W   = 88;

   // Command queue between front and back
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = 1;
   localparam int QUEUE_CNT_W  = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_PLACE = 2'd2;

   // Result kinds
   localparam logic KIND_LIMIT = 1'b0;
   localparam logic KIND_PLACE = 1'b1;

   // Decoded command held in the queue
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [COUNT_W-1:0] count;
      logic [POS_W-1:0]   position;
      logic [HASH_W-1:0]  hash;
   } cmd_type;

   // Table port request from the back end
   typedef struct packed {
      logic               re;
      logic [HASH_W-1:0]  raddr;
      logic               we;
      logic [HASH_W-1:0]  waddr;
      logic [ENTRY_W-1:0] wdata;
   } ram_req_type;

endpackage
`default_nettype wire

@@ hdl/hbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module hbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire  [$clog2(DEPTH)-1:0] waddr,
   input  wire  [WIDTH-1:0]         wdata,
   input  wire                      re,
   input  wire  [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port, and read data that holds until the next read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

@@ hdl/hbs_front.sv @@
// Front end: accepts request words, drops unknown operations, queues commands.
`timescale 1ns / 1ps
`default_nettype none
module hbs_front
   import hbs_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [REQ_DATA_W-1:0] req_tdata,
   input  wire  [OP_W-1:0]       req_tuser,
   output logic                  cmd_valid,
   input  wire                   cmd_ready,
   output cmd_type               cmd
);

   cmd_type                cmd_in;
   cmd_type                q_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   accept;
   logic                   known_op;
   logic                   push;
   logic                   pop;

   // Unpack the word and classify the operation
   always_comb begin
      cmd_in.op       = req_tuser;
      cmd_in.count    = req_tdata[COUNT_W-1:0];
      cmd_in.position = req_tdata[COUNT_W+POS_W-1:COUNT_W];
      cmd_in.hash     = req_tdata[COUNT_W+POS_W+HASH_W-1:COUNT_W+POS_W];
      case (req_tuser)
         OP_START, OP_LOAD, OP_PLACE: known_op = 1'b1;
         default:                     known_op = 1'b0;
      endcase
   end

   assign req_tready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && known_op;
   assign cmd_valid  = (count_ff != '0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = q_mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/hbs_back.sv @@
// Back end: counters, bucket table updates and the result register.
`timescale 1ns / 1ps
`default_nettype none
module hbs_back
   import hbs_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 cmd_valid,
   output logic                cmd_ready,
   input  cmd_type             cmd,
   output ram_req_type         ram_req,
   input  wire  [ENTRY_W-1:0]  ram_rdata,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic                rsp_kind,
   output logic [COUNT_W-1:0]  rsp_limit,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [POS_W-1:0]    rsp_position,
   output logic [NAME_W-1:0]   rsp_name
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WAIT = 1'b1;
   localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(MAX_CHUNKS);

   logic                  state_ff, state_in;
   logic [COUNT_W-1:0]    total_ff, total_in;
   logic [LOAD_IDX_W-1:0] load_idx_ff, load_idx_in;
   logic [NAME_W-1:0]     name_ff, name_in;
   logic [HASH_W-1:0]     hash_ff, hash_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [COUNT_W-1:0]    rsp_limit_ff, rsp_limit_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [NAME_W-1:0]     rsp_name_ff, rsp_name_in;
   logic                  out_free;
   logic                  pop;
   logic [SUM_W-1:0]      sum;
   logic [COUNT_W-1:0]    sat_sum;
   logic                  entry_used;
   logic [COUNT_W-1:0]    entry_end;
   logic [COUNT_W-1:0]    end_dec;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == ST_IDLE) && out_free;
   assign pop       = cmd_valid && cmd_ready;

   // Saturating running total
   assign sum     = {1'b0, total_ff} + {1'b0, cmd.count};
   assign sat_sum = (sum > MAX_SUM) ? MAX_SUM[COUNT_W-1:0] : sum[COUNT_W-1:0];

   assign entry_used = ram_rdata[ENTRY_W-1];
   assign entry_end  = ram_rdata[COUNT_W-1:0];
   assign end_dec    = entry_end - 1'b1;

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      load_idx_in  = load_idx_ff;
      name_in      = name_ff;
      hash_in      = hash_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_limit_in = rsp_limit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_name_in  = rsp_name_ff;
      ram_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               case (cmd.op)
                  OP_START: begin
                     total_in    = '0;
                     load_idx_in = '0;
                     name_in     = '0;
                  end
                  OP_LOAD: begin
                     // Store the bucket end or mark the hash unused
                     if (load_idx_ff < LOAD_IDX_W'(HASH_ENTRIES)) begin
                        load_idx_in   = load_idx_ff + 1'b1;
                        ram_req.we    = 1'b1;
                        ram_req.waddr = load_idx_ff[HASH_W-1:0];
                        if (cmd.count > COUNT_W'(1)) begin
                           total_in      = sat_sum;
                           ram_req.wdata = {1'b1, sat_sum};
                           rsp_valid_in  = 1'b1;
                           rsp_kind_in   = KIND_LIMIT;
                           rsp_limit_in  = sat_sum;
                           rsp_slot_in   = '0;
                           rsp_pos_in    = '0;
                           rsp_name_in   = '0;
                        end else begin
                           ram_req.wdata = '0;
                        end
                     end
                  end
                  OP_PLACE: begin
                     // Fetch the bucket end, finish in the wait state
                     ram_req.re    = 1'b1;
                     ram_req.raddr = cmd.hash;
                     hash_in       = cmd.hash;
                     pos_in        = cmd.position;
                     state_in      = ST_WAIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WAIT: begin
            // Once the result register is free, decrement the end and emit the placement if the bucket has room
            if (out_free) begin
               state_in = ST_IDLE;
               if (entry_used && (entry_end != '0)) begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = hash_ff;
                  ram_req.wdata = {1'b1, end_dec};
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_PLACE;
                  rsp_limit_in  = '0;
                  rsp_slot_in   = end_dec[SLOT_W-1:0];
                  rsp_pos_in    = pos_ff;
                  rsp_name_in   = name_ff;
                  name_in       = name_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         load_idx_ff  <= '0;
         name_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         load_idx_ff  <= load_idx_in;
         name_ff      <= name_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hash_ff      <= hash_in;
      pos_ff       <= pos_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_limit_ff <= rsp_limit_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_name_ff  <= rsp_name_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_limit    = rsp_limit_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_name     = rsp_name_ff;

endmodule
`default_nettype wire

@@ hdl/hash_bucket_scatter_core.sv @@
// Hash bucket scatter: counting-sort bucket ends and chunk placement.
//
// Request channel (req_*): one word per operation, kind in req_tuser
// (start, load next hash count, place chunk; other codes are dropped).
// Result channel (rsp_*): bucket limit words for in-table loads with a count above
// one, placement words for chunks whose hash bucket still has room.
// Accepted words enter a two-word command queue; the back end pops one
// command at a time. A place reads the bucket end from the table RAM and
// writes it back through its single read port and single write port, and
// the back end takes no new command until the place is done.
// While a result waits with rsp_tready low, the result register holds its
// word, the back end stops popping, and req_tready drops once the queue is full.
// Reset clears the counters, the queue and the result register; the bucket
// table is not cleared and a hash must be loaded before chunks are placed.
`timescale 1ns / 1ps
`default_nettype none
module hash_bucket_scatter_core
   import hbs_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   // [16:0] hash_count, [48:17] chunk_position, [58:49] chunk_hash
   input  wire  [REQ_DATA_W-1:0] req_tdata,
   // [1:0] operation
   input  wire  [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   // [16:0] bucket_limit, [32:17] slot, [64:33] out_position, [80:65] chunk_name
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] kind
   output logic                  rsp_tuser
);

   cmd_type            cmd;
   logic               cmd_valid;
   logic               cmd_ready;
   ram_req_type        ram_req;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [COUNT_W-1:0] rsp_limit;
   logic [SLOT_W-1:0]  rsp_slot;
   logic [POS_W-1:0]   rsp_position;
   logic [NAME_W-1:0]  rsp_name;

   hbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   hbs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd),
      .ram_req      (ram_req),
      .ram_rdata    (ram_rdata),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_kind     (rsp_tuser),
      .rsp_limit    (rsp_limit),
      .rsp_slot     (rsp_slot),
      .rsp_position (rsp_position),
      .rsp_name     (rsp_name)
   );

   // Bucket table: used flag and bucket end per hash
   hbs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (HASH_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   // Pack the result word
   assign rsp_tdata = {
      {(RSP_DATA_W - COUNT_W - SLOT_W - POS_W - NAME_W){1'b0}},
      rsp_name, rsp_position, rsp_slot, rsp_limit
   };

`ifndef ASSERT_OFF
   // Table is never read and written in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_req.we && ram_req.re))
      else $error("table read and write in the same cycle");

   // A table read is never directly followed by another read
   a_read_then_wait: assert property (@(posedge clock) disable iff (reset)
      ram_req.re |=> !ram_req.re)
      else $error("back-to-back table reads");

   // A write-back right after a table read brings a placement result
   a_place_writes: assert property (@(posedge clock) disable iff (reset)
      (ram_req.we && !ram_req.re && $past(ram_req.re)) |=> (rsp_tvalid && rsp_tuser == KIND_PLACE))
      else $error("placement write without result");

   // Limit results carry only the bucket limit
   a_limit_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_LIMIT) |->
         (rsp_slot == '0 && rsp_position == '0 && rsp_name == '0))
      else $error("limit result with placement fields set");
`endif

endmodule
`default_nettype wire
